>>> design/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Types, register addresses and a helper function that the bank mapper
// modules share.
// ----------------------------------------------------------------------------
package bmm_pkg;

    // request action codes
    typedef enum logic [1:0] {
        ACT_TRANSLATE = 2'd0,
        ACT_IO_WRITE  = 2'd1,
        ACT_ROM_BANK  = 2'd2,
        ACT_EXT_BANK  = 2'd3
    } action_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_ADDRESS   = 2'd0,
        KIND_OAM_COPY  = 2'd1,
        KIND_VRAM_COPY = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    // configuration port
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam logic        CFG_IDX_ROM_SIZE = 1'b0;

    // i/o register addresses
    localparam logic [15:0] IO_OAM_DMA    = 16'hFF46;
    localparam logic [15:0] IO_VIDEO_BANK = 16'hFF4F;
    localparam logic [15:0] IO_SRC_HIGH   = 16'hFF51;
    localparam logic [15:0] IO_SRC_LOW    = 16'hFF52;
    localparam logic [15:0] IO_DST_HIGH   = 16'hFF53;
    localparam logic [15:0] IO_DST_LOW    = 16'hFF54;
    localparam logic [15:0] IO_XFER_START = 16'hFF55;
    localparam logic [15:0] IO_WORK_BANK  = 16'hFF70;

    // memory map boundaries
    localparam logic [15:0] ECHO_START  = 16'hE000;
    localparam logic [15:0] ECHO_END    = 16'hFE00;
    localparam logic [15:0] ECHO_FOLD   = 16'h2000;
    localparam logic [15:0] ROM_SW_BASE = 16'h4000;
    localparam logic [15:0] VRAM_BASE   = 16'h8000;
    localparam logic [15:0] EXT_BASE    = 16'hA000;
    localparam logic [15:0] WRAM0_BASE  = 16'hC000;
    localparam logic [15:0] WRAM_SW_BASE = 16'hD000;

    // transfer constants
    localparam logic [15:0] OAM_BASE       = 16'hFE00;
    localparam logic [11:0] OAM_LENGTH     = 12'hA0;
    localparam logic [15:0] XFER_SRC_MASK  = 16'hFFF0;
    localparam logic [15:0] XFER_DST_MASK  = 16'h1FF0;
    localparam logic [7:0]  XFER_DONE      = 8'hFF;

    typedef struct packed {
        action_t     action;
        logic [15:0] address;
        logic [7:0]  value;
        logic [8:0]  bank_number;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  bank;
        logic [15:0] offset;
        logic [15:0] copy_source;
        logic [15:0] copy_destination;
        logic [11:0] copy_length;
    } result_t;

    // rom bank mask from the header size code: 16 KiB blocks minus one
    function automatic logic [7:0] rom_mask(input logic [6:0] code);
        logic [17:0] blocks;
        blocks = (18'd2 << code[3:0]) + (((code & 7'h50) != 7'd0) ? 18'd64 : 18'd0)
                 - 18'd1;
        return blocks[7:0];
    endfunction

endpackage

>>> design/bmm_cfg.sv
// ----------------------------------------------------------------------------
// bmm_cfg
// APB-style configuration port holding the cartridge rom size code.
// ----------------------------------------------------------------------------
module bmm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bmm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bmm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bmm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [6:0]                       rom_size_code
);

    logic       wr_en;
    logic       hit_rom_size;
    logic [6:0] rom_size_code_reg;

    // word decode
    assign hit_rom_size = (paddr[2] == bmm_pkg::CFG_IDX_ROM_SIZE);
    assign wr_en        = psel && penable && pwrite && pready;
    assign pready       = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_code_reg <= 7'd0;
        end
        else if (wr_en && hit_rom_size)
        begin
            rom_size_code_reg <= pwdata[6:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (hit_rom_size)
        begin
            prdata = {{(bmm_pkg::CFG_DATA_W-7){1'b0}}, rom_size_code_reg};
        end
    end

    assign rom_size_code = rom_size_code_reg;

endmodule

>>> design/bmm_core.sv
// ----------------------------------------------------------------------------
// bmm_core
// Bank state registers and the single-pass request decode: address
// translation, bank selects and transfer command generation.
// ----------------------------------------------------------------------------
module bmm_core #(
    parameter int unsigned WORK_BANKS  = 8,
    parameter int unsigned VIDEO_BANKS = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  bmm_pkg::item_t   item,
    input  logic [6:0]       rom_size_code,
    output bmm_pkg::result_t result
);

    localparam logic [3:0] WB_COUNT   = 4'(WORK_BANKS);
    localparam logic       VIDEO_MASK = 1'(VIDEO_BANKS - 1);

    logic [7:0]  rom_bank_sel_reg,   rom_bank_sel_next;
    logic        video_bank_sel_reg, video_bank_sel_next;
    logic [2:0]  work_bank_sel_reg,  work_bank_sel_next;
    logic [3:0]  ext_bank_sel_reg,   ext_bank_sel_next;
    logic [15:0] xfer_src_reg,       xfer_src_next;
    logic [15:0] xfer_dst_reg,       xfer_dst_next;
    logic [7:0]  xfer_count_reg,     xfer_count_next;

    logic [15:0] folded;
    logic [3:0]  wb_val;
    logic [11:0] xfer_len;
    logic [15:0] xfer_start_src;
    logic [15:0] xfer_start_dst;

    // echo fold
    always_comb
    begin
        folded = item.address;
        if (item.address >= bmm_pkg::ECHO_START && item.address < bmm_pkg::ECHO_END)
        begin
            folded = item.address - bmm_pkg::ECHO_FOLD;
        end
    end

    // work bank wrap, zero maps to one
    always_comb
    begin
        wb_val = {1'b0, item.value[2:0]};
        for (int i = 0; i < 4; i++)
        begin
            if (wb_val >= WB_COUNT)
            begin
                wb_val = wb_val - WB_COUNT;
            end
        end
        if (wb_val == 4'd0)
        begin
            wb_val = 4'd1;
        end
    end

    // general transfer start and length
    assign xfer_len       = {(5'd0 + item.value[6:0]) + 8'd1, 4'd0};
    assign xfer_start_src = xfer_src_reg & bmm_pkg::XFER_SRC_MASK;
    assign xfer_start_dst = (xfer_dst_reg & bmm_pkg::XFER_DST_MASK) | bmm_pkg::VRAM_BASE;

    // request decode
    always_comb
    begin
        rom_bank_sel_next   = rom_bank_sel_reg;
        video_bank_sel_next = video_bank_sel_reg;
        work_bank_sel_next  = work_bank_sel_reg;
        ext_bank_sel_next   = ext_bank_sel_reg;
        xfer_src_next       = xfer_src_reg;
        xfer_dst_next       = xfer_dst_reg;
        xfer_count_next     = xfer_count_reg;
        result              = '0;
        result.kind         = bmm_pkg::KIND_NONE;

        unique case (item.action)
            bmm_pkg::ACT_TRANSLATE:
            begin
                result.kind   = bmm_pkg::KIND_ADDRESS;
                result.offset = folded;
                priority if (folded >= bmm_pkg::ROM_SW_BASE && folded < bmm_pkg::VRAM_BASE)
                begin
                    result.bank = rom_bank_sel_reg;
                end
                else if (folded >= bmm_pkg::VRAM_BASE && folded < bmm_pkg::EXT_BASE)
                begin
                    result.bank = {7'd0, video_bank_sel_reg};
                end
                else if (folded >= bmm_pkg::EXT_BASE && folded < bmm_pkg::WRAM0_BASE)
                begin
                    result.bank = {4'd0, ext_bank_sel_reg};
                end
                else if (folded >= bmm_pkg::WRAM_SW_BASE && folded < bmm_pkg::ECHO_START)
                begin
                    result.bank = {5'd0, work_bank_sel_reg};
                end
                else
                begin
                    result.bank = 8'd0;
                end
            end
            bmm_pkg::ACT_IO_WRITE:
            begin
                unique case (item.address)
                    bmm_pkg::IO_VIDEO_BANK:
                    begin
                        video_bank_sel_next = item.value[0] & VIDEO_MASK;
                    end
                    bmm_pkg::IO_OAM_DMA:
                    begin
                        if (item.value != 8'd0)
                        begin
                            result.kind             = bmm_pkg::KIND_OAM_COPY;
                            result.copy_source      = {item.value, 8'd0};
                            result.copy_destination = bmm_pkg::OAM_BASE;
                            result.copy_length      = bmm_pkg::OAM_LENGTH;
                        end
                    end
                    bmm_pkg::IO_WORK_BANK:
                    begin
                        work_bank_sel_next = wb_val[2:0];
                    end
                    bmm_pkg::IO_SRC_HIGH:
                    begin
                        xfer_src_next = {item.value, xfer_src_reg[7:0]};
                    end
                    bmm_pkg::IO_SRC_LOW:
                    begin
                        xfer_src_next = {xfer_src_reg[15:8], item.value};
                    end
                    bmm_pkg::IO_DST_HIGH:
                    begin
                        xfer_dst_next = {item.value, xfer_dst_reg[7:0]};
                    end
                    bmm_pkg::IO_DST_LOW:
                    begin
                        xfer_dst_next = {xfer_dst_reg[15:8], item.value};
                    end
                    bmm_pkg::IO_XFER_START:
                    begin
                        if (item.value[7])
                        begin
                            // h-blank mode is only recorded
                            xfer_count_next = item.value;
                        end
                        else
                        begin
                            result.kind             = bmm_pkg::KIND_VRAM_COPY;
                            result.copy_source      = xfer_start_src;
                            result.copy_destination = xfer_start_dst;
                            result.copy_length      = xfer_len;
                            xfer_src_next   = xfer_start_src + {4'd0, xfer_len};
                            xfer_dst_next   = xfer_start_dst + {4'd0, xfer_len};
                            xfer_count_next = bmm_pkg::XFER_DONE;
                        end
                    end
                    default:
                    begin
                        result.kind = bmm_pkg::KIND_NONE;
                    end
                endcase
            end
            bmm_pkg::ACT_ROM_BANK:
            begin
                rom_bank_sel_next = item.bank_number[7:0] & bmm_pkg::rom_mask(rom_size_code);
            end
            bmm_pkg::ACT_EXT_BANK:
            begin
                ext_bank_sel_next = item.bank_number[3:0];
            end
            default:
            begin
                result.kind = bmm_pkg::KIND_NONE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_sel_reg   <= 8'd1;
            video_bank_sel_reg <= 1'b0;
            work_bank_sel_reg  <= 3'd1;
            ext_bank_sel_reg   <= 4'd0;
            xfer_src_reg       <= 16'd0;
            xfer_dst_reg       <= 16'd0;
            xfer_count_reg     <= 8'd0;
        end
        else if (enable)
        begin
            rom_bank_sel_reg   <= rom_bank_sel_next;
            video_bank_sel_reg <= video_bank_sel_next;
            work_bank_sel_reg  <= work_bank_sel_next;
            ext_bank_sel_reg   <= ext_bank_sel_next;
            xfer_src_reg       <= xfer_src_next;
            xfer_dst_reg       <= xfer_dst_next;
            xfer_count_reg     <= xfer_count_next;
        end
    end

endmodule

>>> design/banked_memory_mapper_with_dma.sv
// ----------------------------------------------------------------------------
// banked_memory_mapper_with_dma
// Bank switch state and transfer command issue for an 8-bit handheld map.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request, in order.
// A request is captured in an input register, decoded combinationally
// against the bank state, and its result lands in an output register. A
// stalled output register holds the next request in the input register.
// The block sustains one request per cycle as long as results are taken.
// in_ready drops only when both the input and the output register hold an
// item and out_ready is low. Bank state changes take effect for the very
// next request. The rom size code must be written over the APB port only
// while no request is in flight; the block itself does not enforce it. It
// sets the mask applied to rom bank selects.
module banked_memory_mapper_with_dma #(
    parameter int unsigned WORK_BANKS  = 8,
    parameter int unsigned VIDEO_BANKS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      action,
    input  logic [15:0]                     address,
    input  logic [7:0]                      value,
    input  logic [8:0]                      bank_number,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      bank,
    output logic [15:0]                     offset,
    output logic [15:0]                     copy_source,
    output logic [15:0]                     copy_destination,
    output logic [11:0]                     copy_length,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bmm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bmm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    bmm_pkg::item_t    item_reg;
    bmm_pkg::result_t  result_reg;
    bmm_pkg::result_t  core_result;
    logic              s1_advance;
    logic              core_enable;
    logic              in_fire;
    logic [6:0]        rom_size_code;

    // configuration
    bmm_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .rom_size_code (rom_size_code)
    );

    // decode and bank state
    bmm_core #(
        .WORK_BANKS  (WORK_BANKS),
        .VIDEO_BANKS (VIDEO_BANKS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (core_enable),
        .item          (item_reg),
        .rom_size_code (rom_size_code),
        .result        (core_result)
    );

    // pipeline flow control
    assign s1_advance  = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || s1_advance;
    assign in_fire     = in_valid && in_ready;
    assign core_enable = s1_valid_reg && s1_advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = s1_valid_reg;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= '{action:      bmm_pkg::action_t'(action),
                          address:     address,
                          value:       value,
                          bank_number: bank_number};
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (core_enable)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = result_reg.kind;
    assign bank             = result_reg.bank;
    assign offset           = result_reg.offset;
    assign copy_source      = result_reg.copy_source;
    assign copy_destination = result_reg.copy_destination;
    assign copy_length      = result_reg.copy_length;

    // back pressure only when both stages are full and stalled
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a full, stalled pipeline");

    // translated addresses carry no copy command
    a_addr_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == bmm_pkg::KIND_ADDRESS) |->
        (copy_length == 12'd0 && copy_source == 16'd0 && copy_destination == 16'd0))
        else $error("address result with copy fields set");

    // oam copies are fixed size into object memory
    a_oam_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == bmm_pkg::KIND_OAM_COPY) |->
        (copy_length == bmm_pkg::OAM_LENGTH && copy_destination == bmm_pkg::OAM_BASE
         && copy_source[7:0] == 8'd0))
        else $error("malformed oam copy command");

    // vram copies are whole 16-byte blocks into video ram
    a_vram_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == bmm_pkg::KIND_VRAM_COPY) |->
        (copy_length != 12'd0 && copy_length[3:0] == 4'd0
         && copy_destination[15:13] == 3'b100 && copy_source[3:0] == 4'd0))
        else $error("malformed vram copy command");

endmodule

>>> tb/banked_memory_mapper_with_dma_test.sv
// ----------------------------------------------------------------------------
// banked_memory_mapper_with_dma_test
// Self-checking bench for the bank mapper: requests and results flow over
// valid/ready with random gaps and stalls, a local bank-state model predicts
// every result and a checker compares each one field by field, in order.
// ----------------------------------------------------------------------------
module banked_memory_mapper_with_dma_test;

    import bmm_pkg::*;

    localparam int unsigned WORK_BANKS     = 8;
    localparam int unsigned VIDEO_BANKS    = 2;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          RANDOM_PHASES  = 5;
    localparam int          PHASE_REQUESTS = 110;
    localparam int          REPORT_CAP     = 50;

    // memory map boundaries as the model sees them
    localparam logic [15:0] MAP_ECHO_LO  = 16'hE000;
    localparam logic [15:0] MAP_ECHO_HI  = 16'hFE00;
    localparam logic [15:0] MAP_ECHO_SUB = 16'h2000;
    localparam logic [15:0] MAP_ROMX_LO  = 16'h4000;
    localparam logic [15:0] MAP_VRAM_LO  = 16'h8000;
    localparam logic [15:0] MAP_SRAM_LO  = 16'hA000;
    localparam logic [15:0] MAP_WRAM0_LO = 16'hC000;
    localparam logic [15:0] MAP_WRAMX_LO = 16'hD000;
    localparam logic [15:0] MAP_OAM      = 16'hFE00;
    localparam logic [11:0] MAP_OAM_LEN  = 12'hA0;

    localparam logic [CFG_ADDR_W-1:0] ROM_SIZE_ADDR = {CFG_IDX_ROM_SIZE, 2'b00};

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             action;
    logic [15:0]            address;
    logic [7:0]             value;
    logic [8:0]             bank_number;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             kind;
    logic [7:0]             bank;
    logic [15:0]            offset;
    logic [15:0]            copy_source;
    logic [15:0]            copy_destination;
    logic [11:0]            copy_length;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // local copy of the bank state
    logic [6:0]  rom_size_q;
    logic [7:0]  rom_bank_q;
    logic        video_bank_q;
    logic [2:0]  work_bank_q;
    logic [3:0]  ext_bank_q;
    logic [15:0] dma_src_q;
    logic [15:0] dma_dst_q;
    logic [7:0]  hdma_count_q;

    result_t expected_results[$];
    int      mismatch_count;
    int      results_seen;
    int      idle_cycles;
    int      stall_left;
    bit      no_idling;

    banked_memory_mapper_with_dma #(
        .WORK_BANKS  (WORK_BANKS),
        .VIDEO_BANKS (VIDEO_BANKS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .address          (address),
        .value            (value),
        .bank_number      (bank_number),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .bank             (bank),
        .offset           (offset),
        .copy_source      (copy_source),
        .copy_destination (copy_destination),
        .copy_length      (copy_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // rom bank mask: number of 16 KiB blocks in the cartridge, minus one
    function automatic logic [7:0] rom_bank_mask(input logic [6:0] code);
        longint unsigned rom_bytes;
        rom_bytes = 64'h8000 << code[3:0];
        if ((code & 7'h50) != 7'd0)
            rom_bytes += 64'd1 << 20;
        return 8'((rom_bytes >> 14) - 1);
    endfunction

    task automatic reset_mapper_model();
        rom_size_q   = 7'd0;
        rom_bank_q   = 8'd1;
        video_bank_q = 1'b0;
        work_bank_q  = 3'd1;
        ext_bank_q   = 4'd0;
        dma_src_q    = 16'd0;
        dma_dst_q    = 16'd0;
        hdma_count_q = 8'd0;
    endtask

    // expected result of one request; updates the local bank state
    function automatic result_t predict_mapper_result(input item_t req);
        result_t     res;
        logic [15:0] addr;
        logic [15:0] src;
        logic [15:0] dst;
        int unsigned wb;
        int unsigned vb;
        int unsigned len;
        res = '0;
        res.kind = KIND_NONE;
        case (req.action)
            ACT_TRANSLATE:
            begin
                addr = req.address;
                if (addr >= MAP_ECHO_LO && addr < MAP_ECHO_HI)
                    addr = addr - MAP_ECHO_SUB;
                res.kind = KIND_ADDRESS;
                res.offset = addr;
                if (addr >= MAP_ROMX_LO && addr < MAP_VRAM_LO)
                    res.bank = rom_bank_q;
                else if (addr >= MAP_VRAM_LO && addr < MAP_SRAM_LO)
                    res.bank = {7'd0, video_bank_q};
                else if (addr >= MAP_SRAM_LO && addr < MAP_WRAM0_LO)
                    res.bank = {4'd0, ext_bank_q};
                else if (addr >= MAP_WRAMX_LO && addr < MAP_ECHO_LO)
                    res.bank = {5'd0, work_bank_q};
            end
            ACT_IO_WRITE:
            begin
                case (req.address)
                    IO_VIDEO_BANK:
                    begin
                        vb = req.value & (VIDEO_BANKS - 1);
                        video_bank_q = vb[0];
                    end
                    IO_OAM_DMA:
                    begin
                        if (req.value != 8'd0)
                        begin
                            res.kind = KIND_OAM_COPY;
                            res.copy_source = {req.value, 8'h00};
                            res.copy_destination = MAP_OAM;
                            res.copy_length = MAP_OAM_LEN;
                        end
                    end
                    IO_WORK_BANK:
                    begin
                        wb = req.value & 8'h07;
                        if (wb >= WORK_BANKS)
                            wb = wb % WORK_BANKS;
                        if (wb == 0)
                            wb = 1;
                        work_bank_q = wb[2:0];
                    end
                    IO_SRC_HIGH: dma_src_q[15:8] = req.value;
                    IO_SRC_LOW:  dma_src_q[7:0] = req.value;
                    IO_DST_HIGH: dma_dst_q[15:8] = req.value;
                    IO_DST_LOW:  dma_dst_q[7:0] = req.value;
                    IO_XFER_START:
                    begin
                        if (req.value[7])
                            hdma_count_q = req.value;
                        else
                        begin
                            // general transfer: 16-byte blocks, vram destination
                            src = dma_src_q & 16'hFFF0;
                            dst = (dma_dst_q & 16'h1FF0) | MAP_VRAM_LO;
                            len = (int'(req.value) + 1) * 16;
                            res.kind = KIND_VRAM_COPY;
                            res.copy_source = src;
                            res.copy_destination = dst;
                            res.copy_length = len[11:0];
                            dma_src_q = src + len[15:0];
                            dma_dst_q = dst + len[15:0];
                            hdma_count_q = 8'hFF;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ACT_ROM_BANK: rom_bank_q = req.bank_number[7:0] & rom_bank_mask(rom_size_q);
            default:      ext_bank_q = req.bank_number[3:0];
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h expected %h",
                                      results_seen, name, got, want));
    endtask

    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int request_gap();
        if (no_idling || $urandom_range(0, 99) < 55)
            return 0;
        return idle_length();
    endfunction

    // send one request; called and returns at a rising edge, valid left high
    task automatic send_request(input action_t act, input logic [15:0] addr,
                                input logic [7:0] val, input logic [8:0] bnk);
        item_t req;
        int    gap;
        bit    taken;
        req.action = act;
        req.address = addr;
        req.value = val;
        req.bank_number = bnk;
        gap = request_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        address     <= addr;
        value       <= val;
        bank_number <= bnk;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken)
                expected_results.push_back(predict_mapper_result(req));
            @(posedge clk);
        end
    endtask

    // stop sending and wait for every pending result, plus the pipeline depth
    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write of the rom size code, then read it back
    task automatic program_rom_size(input logic [6:0] code);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROM_SIZE_ADDR;
        pwdata  <= {25'd0, code};
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rom_size_q = code;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= ROM_SIZE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        if (prdata !== {25'd0, code})
            report_mismatch($sformatf("rom size read back %h expected %h", prdata, code));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random request, or a whole general-transfer setup sequence
    task automatic send_random_request(output int sent);
        logic [15:0] io_regs[8];
        logic [15:0] edges[15];
        logic [15:0] addr;
        logic [7:0]  val;
        int          pick;
        io_regs = '{IO_OAM_DMA, IO_VIDEO_BANK, IO_SRC_HIGH, IO_SRC_LOW,
                    IO_DST_HIGH, IO_DST_LOW, IO_XFER_START, IO_WORK_BANK};
        edges = '{16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000,
                  16'hBFFF, 16'hC000, 16'hCFFF, 16'hD000, 16'hDFFF, 16'hE000,
                  16'hFDFF, 16'hFE00, 16'hFFFF};
        pick = $urandom_range(0, 99);
        sent = 1;
        if (pick < 10)
        begin
            val = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
                                               : 8'($urandom_range(128, 255));
            send_request(ACT_IO_WRITE, IO_SRC_HIGH, 8'($urandom), 9'($urandom));
            send_request(ACT_IO_WRITE, IO_SRC_LOW, 8'($urandom), 9'($urandom));
            send_request(ACT_IO_WRITE, IO_DST_HIGH, 8'($urandom), 9'($urandom));
            send_request(ACT_IO_WRITE, IO_DST_LOW, 8'($urandom), 9'($urandom));
            send_request(ACT_IO_WRITE, IO_XFER_START, val, 9'($urandom));
            sent = 5;
        end
        else if (pick < 42)
        begin
            addr = ($urandom_range(0, 99) < 30) ? edges[$urandom_range(0, 14)]
                                                : 16'($urandom);
            send_request(ACT_TRANSLATE, addr, 8'($urandom), 9'($urandom));
        end
        else if (pick < 72)
        begin
            addr = ($urandom_range(0, 99) < 85) ? io_regs[$urandom_range(0, 7)]
                                                : 16'($urandom);
            val = 8'($urandom);
            if (addr == IO_XFER_START && $urandom_range(0, 99) < 70)
                val[7] = 1'b0;
            send_request(ACT_IO_WRITE, addr, val, 9'($urandom));
        end
        else if (pick < 86)
            send_request(ACT_ROM_BANK, 16'($urandom), 8'($urandom), 9'($urandom));
        else
            send_request(ACT_EXT_BANK, 16'($urandom), 8'($urandom), 9'($urandom));
    endtask

    // fixed regions, switchable regions and echo folding straight after reset
    task automatic test_reset_map();
        send_request(ACT_TRANSLATE, 16'h0000, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'h7FFF, 8'hFF, 9'h1FF);
        send_request(ACT_TRANSLATE, 16'hA000, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'hE000, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'hFDFF, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'hFE00, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'hFFFF, 8'hFF, 9'h1FF);
    endtask

    // bank selects at their extremes, work bank zero, oversized external bank
    task automatic test_bank_registers();
        send_request(ACT_ROM_BANK, 16'h0000, 8'h00, 9'h1FF);
        send_request(ACT_EXT_BANK, 16'h0000, 8'h00, 9'h1FF);
        send_request(ACT_IO_WRITE, IO_VIDEO_BANK, 8'hFF, 9'h000);
        send_request(ACT_IO_WRITE, IO_WORK_BANK, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'h9FFF, 8'h00, 9'h000);
        send_request(ACT_TRANSLATE, 16'hBFFF, 8'h00, 9'h000);
        send_request(ACT_IO_WRITE, IO_WORK_BANK, 8'hFF, 9'h000);
        send_request(ACT_TRANSLATE, 16'hF000, 8'h00, 9'h000);
    endtask

    // oam copies, general transfers, h-blank requests and an unknown register
    task automatic test_transfers();
        send_request(ACT_IO_WRITE, IO_OAM_DMA, 8'h00, 9'h000);
        send_request(ACT_IO_WRITE, IO_OAM_DMA, 8'hFF, 9'h000);
        send_request(ACT_IO_WRITE, IO_SRC_HIGH, 8'hFF, 9'h000);
        send_request(ACT_IO_WRITE, IO_SRC_LOW, 8'hFF, 9'h000);
        send_request(ACT_IO_WRITE, IO_DST_HIGH, 8'hFF, 9'h000);
        send_request(ACT_IO_WRITE, IO_DST_LOW, 8'hFF, 9'h000);
        send_request(ACT_IO_WRITE, IO_XFER_START, 8'h7F, 9'h000);
        send_request(ACT_IO_WRITE, IO_XFER_START, 8'h00, 9'h000);
        send_request(ACT_IO_WRITE, IO_XFER_START, 8'h80, 9'h000);
        send_request(ACT_IO_WRITE, 16'h1234, 8'hAA, 9'h155);
    endtask

    // rom bank mask at the largest size code and at a full 4-bit shift
    task automatic test_rom_size_codes();
        drain_requests();
        program_rom_size(7'd84);
        send_request(ACT_ROM_BANK, 16'h0000, 8'h00, 9'h1FF);
        send_request(ACT_TRANSLATE, 16'h5555, 8'h00, 9'h000);
        drain_requests();
        program_rom_size(7'h0F);
        send_request(ACT_ROM_BANK, 16'h0000, 8'h00, 9'h1FF);
        send_request(ACT_TRANSLATE, 16'h5555, 8'h00, 9'h000);
    endtask

    // random traffic over several size codes, one phase without any idling
    task automatic test_random_traffic();
        int sent;
        int count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_requests();
            program_rom_size((phase == RANDOM_PHASES - 1) ? 7'd0
                                                          : 7'($urandom_range(0, 84)));
            no_idling = (phase == 2);
            sent = 0;
            while (sent < PHASE_REQUESTS)
            begin
                send_random_request(count);
                sent += count;
            end
        end
        no_idling = 1'b0;
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!no_idling && $urandom_range(0, 99) < 20)
        begin
            stall_left = idle_length() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // compare each accepted result with the oldest expectation
    always @(negedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d with no request pending",
                                          results_seen));
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 16'(kind), 16'(want.kind));
                check_field("bank", 16'(bank), 16'(want.bank));
                check_field("offset", offset, want.offset);
                check_field("copy_source", copy_source, want.copy_source);
                check_field("copy_destination", copy_destination, want.copy_destination);
                check_field("copy_length", 16'(copy_length), 16'(want.copy_length));
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any handshake
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        mismatch_count = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        no_idling      = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        action      <= ACT_TRANSLATE;
        address     <= 16'd0;
        value       <= 8'd0;
        bank_number <= 9'd0;
        out_ready   <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        reset_mapper_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_map();
        test_bank_registers();
        test_transfers();
        test_rom_size_codes();
        test_random_traffic();

        drain_requests();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/bmm_pkg.sv
design/bmm_cfg.sv
design/bmm_core.sv
design/banked_memory_mapper_with_dma.sv
tb/banked_memory_mapper_with_dma_test.sv
